// ===== rtl/core/mpsa_pkg.sv =====
package mpsa_pkg;

    // Pool and slot geometry.
    localparam int MAX_SLOTS     = 1024;
    localparam int POOL_COUNT    = 4;
    localparam int NUM_CFG_POOLS = 4;

    // Field widths of the transactions and registers.
    localparam int OP_W     = 1;
    localparam int POOL_W   = 2;
    localparam int SLOT_W   = 11;
    localparam int SIZE_W   = 13;
    localparam int OFF_W    = 22;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Free map layout: rows of 32 slots, one 32-bit slice per pool in each row.
    localparam int ROW_W   = 32;
    localparam int COL_W   = 5;
    localparam int ROWS    = (MAX_SLOTS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT0_W = ROW_AW + COL_W;
    localparam int MEM_W   = POOL_COUNT * ROW_W;
    localparam int PROD_W  = SLOT0_W + SIZE_W;

    // Limits and reset values.
    localparam logic [SLOT_W-1:0] COUNT_LIMIT = SLOT_W'(MAX_SLOTS);
    localparam logic [SIZE_W-1:0] SIZE_LIMIT  = SIZE_W'(4096);
    localparam logic [SLOT_W-1:0] COUNT_RESET = SLOT_W'(1024);
    localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(256);
    localparam logic [OFF_W-1:0]  OFF_MAX     = '1;
    localparam logic [POOL_W-1:0] POOL_LAST   = POOL_W'(POOL_COUNT - 1);

    // Request kinds.
    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATERIAL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PBR_COUNT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKINNED_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MATERIAL_SIZE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PBR_SIZE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SKINNED_SIZE   = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic look;
        logic read;
        logic decide;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // Lowest set bit of a row slice.
    function automatic logic [COL_W-1:0] lowest_col(input logic [ROW_W-1:0] v);
        logic [COL_W-1:0] r;
        r = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (v[i]) r = COL_W'(i);
        end
        return r;
    endfunction

    // Lowest set bit of a row summary.
    function automatic logic [ROW_AW-1:0] lowest_row(input logic [ROWS-1:0] v);
        logic [ROW_AW-1:0] r;
        r = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (v[i]) r = ROW_AW'(i);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/mpsa_ctrl.sv =====
module mpsa_ctrl
    import mpsa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOK   = 5'b00010,
        S_READ   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands for the current step; no request is taken during reset.
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/mpsa_dp.sv =====
module mpsa_dp
    import mpsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [OP_W-1:0]       in_op,
    input  logic [POOL_W-1:0]     in_pool,
    input  logic [SLOT_W-1:0]     in_slot_index,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SLOT_W-1:0]     m_granted_index,
    output logic [OFF_W-1:0]      m_byte_offset,
    output status_t               m_status
);

    // Configuration registers.
    logic [SLOT_W-1:0] count_reg [NUM_CFG_POOLS];
    logic [SIZE_W-1:0] size_reg  [NUM_CFG_POOLS];

    // Request registers.
    logic [OP_W-1:0]    op_reg;
    logic [POOL_W-1:0]  pool_reg;
    logic [SLOT_W-1:0]  idx_reg;
    logic [ROW_AW-1:0]  row_reg;
    logic [COL_W-1:0]   col_reg;
    logic               fail_reg;
    status_t            status_reg;
    logic [SLOT_W-1:0]  grant_reg;

    // Free map storage, row valid bits and per-pool row summaries.
    logic [MEM_W-1:0]   free_mem [ROWS];
    logic [ROWS-1:0]    row_valid_reg;
    logic [ROWS-1:0]    nonfull_reg [POOL_COUNT];
    logic [MEM_W-1:0]   rd_data_reg;
    logic               rd_valid_reg;

    // Output register.
    logic               m_tvalid_reg;
    logic [SLOT_W-1:0]  m_grant_reg;
    logic [OFF_W-1:0]   m_off_reg;
    status_t            m_status_reg;

    // Combinational helpers.
    logic [POOL_W-1:0]  pool_sel;
    logic [SLOT_W-1:0]  cnt_eff;
    logic [SIZE_W-1:0]  size_eff;
    logic [SLOT_W-1:0]  idx_m1;
    logic [ROWS-1:0]    summary;
    logic [MEM_W-1:0]   row_bits;
    logic [ROW_W-1:0]   pool_bits;
    logic [COL_W-1:0]   alloc_col;
    logic [SLOT_W-1:0]  alloc_grant;
    logic [ROW_W-1:0]   new_pool_bits;
    logic [MEM_W-1:0]   new_row;
    logic               dec_fail;
    status_t            dec_status;
    logic [SLOT_W-1:0]  dec_grant;
    logic [SLOT_W-1:0]  grant_m1;
    logic [PROD_W-1:0]  prod;
    logic [OFF_W-1:0]   off_sat;

    // Requests to a pool beyond the last one go to the last pool.
    assign pool_sel = (in_pool > POOL_LAST) ? POOL_LAST : in_pool;

    // Effective count and slot size of the pool in hand.
    assign cnt_eff  = (count_reg[pool_reg] > COUNT_LIMIT) ? COUNT_LIMIT : count_reg[pool_reg];
    assign size_eff = (size_reg[pool_reg] > SIZE_LIMIT) ? SIZE_LIMIT : size_reg[pool_reg];
    assign idx_m1   = idx_reg - SLOT_W'(1);
    assign summary  = nonfull_reg[pool_reg];

    // Decision on the row read from the free map.
    always_comb begin
        row_bits      = rd_valid_reg ? rd_data_reg : '1;
        pool_bits     = row_bits[pool_reg*ROW_W +: ROW_W];
        alloc_col     = lowest_col(pool_bits);
        alloc_grant   = SLOT_W'({row_reg, alloc_col}) + SLOT_W'(1);
        new_pool_bits = pool_bits;
        dec_fail      = fail_reg;
        dec_status    = status_reg;
        dec_grant     = idx_reg;
        if (op_reg == OP_ALLOC) begin
            dec_grant = alloc_grant;
            new_pool_bits[alloc_col] = 1'b0;
            if (!fail_reg && (alloc_grant > cnt_eff)) begin
                dec_fail   = 1'b1;
                dec_status = ST_EMPTY;
            end
        end else begin
            new_pool_bits[col_reg] = 1'b1;
            if (!fail_reg && pool_bits[col_reg]) begin
                dec_fail   = 1'b1;
                dec_status = ST_BAD;
            end
        end
        new_row = row_bits;
        new_row[pool_reg*ROW_W +: ROW_W] = new_pool_bits;
    end

    // Byte offset of the granted slot, saturated to the field width.
    assign grant_m1 = grant_reg - SLOT_W'(1);
    assign prod     = PROD_W'(grant_m1[SLOT0_W-1:0]) * PROD_W'(size_eff);
    assign off_sat  = (prod > PROD_W'(OFF_MAX)) ? OFF_MAX : prod[OFF_W-1:0];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_CFG_POOLS; p++) begin
                count_reg[p] <= COUNT_RESET;
                size_reg[p]  <= SIZE_RESET;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OBJECT_COUNT:   count_reg[0] <= cfg_data[SLOT_W-1:0];
                CFG_MATERIAL_COUNT: count_reg[1] <= cfg_data[SLOT_W-1:0];
                CFG_PBR_COUNT:      count_reg[2] <= cfg_data[SLOT_W-1:0];
                CFG_SKINNED_COUNT:  count_reg[3] <= cfg_data[SLOT_W-1:0];
                CFG_OBJECT_SIZE:    size_reg[0]  <= cfg_data[SIZE_W-1:0];
                CFG_MATERIAL_SIZE:  size_reg[1]  <= cfg_data[SIZE_W-1:0];
                CFG_PBR_SIZE:       size_reg[2]  <= cfg_data[SIZE_W-1:0];
                CFG_SKINNED_SIZE:   size_reg[3]  <= cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Request capture, row lookup and decision.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_op;
            pool_reg <= pool_sel;
            idx_reg  <= in_slot_index;
        end
        if (cmd.look) begin
            if (op_reg == OP_ALLOC) begin
                fail_reg   <= ~|summary;
                status_reg <= ST_EMPTY;
                row_reg    <= lowest_row(summary);
            end else begin
                fail_reg   <= (idx_reg == '0) || (idx_reg > cnt_eff);
                status_reg <= ST_BAD;
                row_reg    <= idx_m1[SLOT0_W-1:COL_W];
                col_reg    <= idx_m1[COL_W-1:0];
            end
        end
        if (cmd.decide) begin
            fail_reg   <= dec_fail;
            status_reg <= dec_status;
            grant_reg  <= dec_grant;
        end
    end

    // Free map memory: one registered read and one write port.
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_data_reg <= free_mem[row_reg];
        end
        if (cmd.decide && !dec_fail) begin
            free_mem[row_reg] <= new_row;
        end
    end

    // Row valid bits and row summaries; a row never written reads as all free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            for (int p = 0; p < POOL_COUNT; p++) begin
                nonfull_reg[p] <= '1;
            end
        end else if (cmd.decide && !dec_fail) begin
            row_valid_reg[row_reg]          <= 1'b1;
            nonfull_reg[pool_reg][row_reg]  <= |new_pool_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_valid_reg <= row_valid_reg[row_reg];
        end
    end

    // Output register; failures carry a zero index and offset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_grant_reg  <= fail_reg ? '0 : grant_reg;
            m_off_reg    <= fail_reg ? '0 : off_sat;
            m_status_reg <= fail_reg ? status_reg : ST_OK;
        end
    end

    assign stat.out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_granted_index = m_grant_reg;
    assign m_byte_offset   = m_off_reg;
    assign m_status        = m_status_reg;

endmodule

// ===== rtl/core/multi_pool_slot_allocator.sv =====
// Channel  Direction  Handshake             Payload
// s_       in         s_tvalid / s_tready   s_tdata: slot_index; s_tuser: op, pool
// m_       out        m_tvalid / m_tready   m_tdata: granted_index, byte_offset;
//                                           m_tuser: status
// cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request at a time: four controller steps from acceptance to the result register
// (summary search, free map row read, decision and write-back, offset multiply into the
// output register); the next request is taken only in the idle step after these.
// A request can be accepted while the previous result still waits on m_.
// A result stalled by m_tready holds the controller in its final step.
// Reset is synchronous and refuses requests; row valid bits clear the free map at once.
module multi_pool_slot_allocator
    import mpsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [10:0] slot_index
    input  logic [2:0]            s_tuser,   // [0] op, [2:1] pool
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [10:0] granted_index, [32:11] byte_offset
    output logic [STATUS_W-1:0]   m_tuser,   // [1:0] status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [SLOT_W-1:0] granted_index;
    logic [OFF_W-1:0]  byte_offset;
    status_t           status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    mpsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpsa_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_tuser[OP_W-1:0]),
        .in_pool         (s_tuser[OP_W +: POOL_W]),
        .in_slot_index   (s_tdata[SLOT_W-1:0]),
        .cfg_we          (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_granted_index (granted_index),
        .m_byte_offset   (byte_offset),
        .m_status        (status)
    );

    // Pack the result fields, lowest field first, zero-filled to whole bytes.
    assign m_tdata = {7'd0, byte_offset, granted_index};
    assign m_tuser = status;

endmodule

// ===== rtl/core/mpsa_checker.sv =====
module mpsa_checker
    import mpsa_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [39:0]           m_tdata,
    input logic [STATUS_W-1:0]   m_tuser
);

    // No result is offered straight after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in progress");

    // A successful result names a real slot.
    a_ok_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_OK) |-> (m_tdata[10:0] != 11'd0))
        else $error("successful result with slot index zero");

    // A failed result carries no slot and no offset, and a known status.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |->
            (m_tdata[32:0] == 33'd0) && ((m_tuser == ST_EMPTY) || (m_tuser == ST_BAD)))
        else $error("failed result with slot fields or unknown status");

endmodule

bind multi_pool_slot_allocator mpsa_checker u_mpsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
